[hw/rtl/cst_pkg.sv]
// Shared constants, types and helpers of the counting semaphore table.
`default_nettype none

package cst_pkg;

  localparam int NUM_SEMS   = 32;
  localparam int NUM_PROCS  = 32;
  localparam int COUNT_BITS = 16;

  localparam int SLOT_W   = $clog2(NUM_SEMS);
  localparam int PROC_W   = $clog2(NUM_PROCS);
  localparam int WALK_MAX = (NUM_PROCS < 32) ? NUM_PROCS : 32;
  localparam int WALK_W   = $clog2(WALK_MAX);

  localparam logic [32:0] COUNT_MAX_W = (33'd1 << COUNT_BITS) - 33'd1;

  typedef logic [SLOT_W-1:0]     slot_t;
  typedef logic [PROC_W-1:0]     proc_t;
  typedef logic [COUNT_BITS-1:0] cnt_t;
  typedef logic [WALK_W-1:0]     walk_t;

  // Request codes
  localparam logic [1:0] REQ_CREATE  = 2'd0;
  localparam logic [1:0] REQ_ACQUIRE = 2'd1;
  localparam logic [1:0] REQ_RELEASE = 2'd2;
  localparam logic [1:0] REQ_FREE    = 2'd3;

  // Result status codes
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_ERROR   = 3'd1;
  localparam logic [2:0] ST_BLOCKED = 3'd2;
  localparam logic [2:0] ST_FREED   = 3'd3;
  localparam logic [2:0] ST_WAITER  = 3'd4;

  typedef struct packed {
    cnt_t  count;
    proc_t head;
    proc_t tail;
  } slot_row_t;

  localparam int ROW_W = $bits(slot_row_t);

  typedef struct packed {
    logic  found;
    slot_t slot;
  } free_find_t;

  // Clamp a non-negative create count to the count width
  function automatic cnt_t sat_count(input logic [15:0] c);
    logic [32:0] w;
    w = 33'(c);
    if (w > COUNT_MAX_W) begin
      return cnt_t'(COUNT_MAX_W);
    end
    return cnt_t'(w);
  endfunction

endpackage

`default_nettype wire

[hw/rtl/cst_if.sv]
// Request and response channel interfaces of the semaphore table.
`default_nettype none

interface cst_req_if;
  logic               valid;
  logic               ready;
  logic [1:0]         req_type;
  logic [7:0]         sem_index;
  logic signed [15:0] initial_count;
  logic [4:0]         requester_id;

  modport source(output valid, output req_type, output sem_index,
                 output initial_count, output requester_id, input ready);
  modport sink(input valid, input req_type, input sem_index,
               input initial_count, input requester_id, output ready);
endinterface

interface cst_rsp_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic [4:0] handle;
  logic       waiter_valid;
  logic [4:0] waiter_id;
  logic       waiter_killed;
  logic       last;

  modport source(output valid, output status, output handle, output waiter_valid,
                 output waiter_id, output waiter_killed, output last, input ready);
  modport sink(input valid, input status, input handle, input waiter_valid,
               input waiter_id, input waiter_killed, input last, output ready);
endinterface

`default_nettype wire

[hw/rtl/cst_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
`default_nettype none

module cst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Hold read data until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

[hw/rtl/cst_free_find.sv]
// Lowest-free-slot search over the slot active flags.
`default_nettype none

module cst_free_find import cst_pkg::*; (
  input  logic [NUM_SEMS-1:0] active,
  output free_find_t          res
);

  always_comb begin
    res.found = 1'b0;
    res.slot  = '0;
    // Scan downwards so the lowest free slot wins
    for (int i = NUM_SEMS - 1; i >= 0; i--) begin
      if (!active[i]) begin
        res.found = 1'b1;
        res.slot  = slot_t'(i);
      end
    end
  end

endmodule

`default_nettype wire

[hw/rtl/counting_semaphore_table_unit.sv]
// Top level of the counting semaphore table: sequencer, slot and link memories.
`default_nettype none

// A table of NUM_SEMS counting semaphores, each with a FIFO queue of blocked
// process ids. One request is handled at a time. For create, acquire (P) and
// most release (V) requests the accepting cycle issues the read of the slot
// row from its synchronous memory, and the execute state updates it and loads
// the result register once that register is free. A release that wakes a
// waiter while others remain queued then passes through a head-update state,
// since the new queue head comes from a read of the waiter link memory. Free
// with n queued waiters gives n + 1 results: the link memory is walked one
// waiter per cycle while the result register is free. The result register
// decouples the two channels, so a new request is taken as soon as the
// previous one has finished its memory updates, even while its last result
// waits to be consumed. Slot count, queue head/tail and links are not cleared
// at reset; only the per-slot active and queue-occupied flags are.
module counting_semaphore_table_unit import cst_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  cst_req_if.sink    req,
  cst_rsp_if.source  rsp
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_EXEC  = 4'b0010,
    S_VNEXT = 4'b0100,
    S_WALK  = 4'b1000
  } state_t;

  state_t state, state_next;

  // Latched request
  logic [1:0]  lat_req;
  logic [7:0]  lat_idx;
  logic [15:0] lat_cnt;
  logic [4:0]  lat_pid;

  // Per-slot flags in flip-flops, cleared by reset
  logic [NUM_SEMS-1:0] slot_active;
  logic [NUM_SEMS-1:0] slot_nonempty;

  // Free walk
  proc_t walk_w, walk_w_next;
  logic  walk_from_rd, walk_from_rd_next;
  walk_t walk_n, walk_n_next;

  // Result register
  logic       out_valid;
  logic [2:0] out_status;
  logic [4:0] out_handle;
  logic       out_wv;
  logic [4:0] out_wid;
  logic       out_wk;
  logic       out_last;

  // Memory ports
  logic       slot_rd_en;
  slot_t      slot_rd_addr;
  logic [ROW_W-1:0] slot_rd_data;
  logic       slot_wr_en;
  slot_t      slot_wr_addr;
  slot_row_t  slot_wr_row;
  logic       link_rd_en;
  proc_t      link_rd_addr;
  proc_t      link_rd_data;
  logic       link_wr_en;
  proc_t      link_wr_addr;
  proc_t      link_wr_data;

  // Flag updates
  logic  act_wr_en, act_wr_val;
  slot_t act_wr_addr;
  logic  ne_wr_en, ne_wr_val;
  slot_t ne_wr_addr;

  // Result load
  logic       emit;
  logic [2:0] e_status;
  logic [4:0] e_handle;
  logic       e_wv;
  proc_t      e_wid;
  logic       e_wk;
  logic       e_last;

  free_find_t ff;
  slot_row_t  row;
  slot_t      idx_s;
  logic       in_range, sel_active, sel_nonempty, pid_ok, out_free, walk_end;
  proc_t      pid_p, cur_w;

  cst_ram #(.WIDTH(ROW_W), .DEPTH(NUM_SEMS)) u_slot_ram (
    .clk     (clk),
    .rd_en   (slot_rd_en),
    .rd_addr (slot_rd_addr),
    .rd_data (slot_rd_data),
    .wr_en   (slot_wr_en),
    .wr_addr (slot_wr_addr),
    .wr_data (slot_wr_row)
  );

  cst_ram #(.WIDTH(PROC_W), .DEPTH(NUM_PROCS)) u_link_ram (
    .clk     (clk),
    .rd_en   (link_rd_en),
    .rd_addr (link_rd_addr),
    .rd_data (link_rd_data),
    .wr_en   (link_wr_en),
    .wr_addr (link_wr_addr),
    .wr_data (link_wr_data)
  );

  cst_free_find u_free_find (
    .active (slot_active),
    .res    (ff)
  );

  assign row          = slot_row_t'(slot_rd_data);
  assign idx_s        = slot_t'(lat_idx);
  assign in_range     = {1'b0, lat_idx} < 9'(NUM_SEMS);
  assign sel_active   = slot_active[idx_s];
  assign sel_nonempty = slot_nonempty[idx_s];
  assign pid_ok       = {1'b0, lat_pid} < 6'(NUM_PROCS);
  assign pid_p        = proc_t'(lat_pid);
  assign out_free     = !out_valid || rsp.ready;
  // Walk position comes from the link read once the first waiter is out
  assign cur_w        = walk_from_rd ? link_rd_data : walk_w;
  assign walk_end     = (cur_w == row.tail) || (walk_n == walk_t'(WALK_MAX - 1));

  assign req.ready    = (state == S_IDLE);
  // Read the addressed row as the request is taken
  assign slot_rd_en   = req.valid && (state == S_IDLE);
  assign slot_rd_addr = slot_t'(req.sem_index);

  always_comb begin
    state_next        = state;
    walk_w_next       = walk_w;
    walk_from_rd_next = walk_from_rd;
    walk_n_next       = walk_n;
    slot_wr_en        = 1'b0;
    slot_wr_addr      = idx_s;
    slot_wr_row       = row;
    link_rd_en        = 1'b0;
    link_rd_addr      = row.head;
    link_wr_en        = 1'b0;
    link_wr_addr      = row.tail;
    link_wr_data      = pid_p;
    act_wr_en         = 1'b0;
    act_wr_addr       = idx_s;
    act_wr_val        = 1'b0;
    ne_wr_en          = 1'b0;
    ne_wr_addr        = idx_s;
    ne_wr_val         = 1'b0;
    emit              = 1'b0;
    e_status          = ST_OK;
    e_handle          = '0;
    e_wv              = 1'b0;
    e_wid             = '0;
    e_wk              = 1'b0;
    e_last            = 1'b1;

    case (state)
      S_IDLE: begin
        if (req.valid) begin
          state_next = S_EXEC;
        end
      end

      S_EXEC: begin
        // Every request gives a result here; hold until the result register frees
        if (out_free) begin
          emit       = 1'b1;
          state_next = S_IDLE;
          if (lat_req == REQ_CREATE) begin
            if (lat_cnt[15] || !ff.found) begin
              e_status = ST_ERROR;
            end else begin
              slot_wr_en        = 1'b1;
              slot_wr_addr      = ff.slot;
              slot_wr_row.count = sat_count(lat_cnt);
              act_wr_en         = 1'b1;
              act_wr_addr       = ff.slot;
              act_wr_val        = 1'b1;
              ne_wr_en          = 1'b1;
              ne_wr_addr        = ff.slot;
              e_handle          = 5'(ff.slot);
            end
          end else if (!in_range || !sel_active) begin
            e_status = ST_ERROR;
          end else begin
            case (lat_req)
              REQ_ACQUIRE: begin
                if (row.count != '0) begin
                  slot_wr_en        = 1'b1;
                  slot_wr_row.count = row.count - 1'b1;
                end else if (!pid_ok) begin
                  e_status = ST_ERROR;
                end else begin
                  // Append the caller; link it behind the old tail if queued
                  link_wr_en       = sel_nonempty;
                  slot_wr_en       = 1'b1;
                  slot_wr_row.head = sel_nonempty ? row.head : pid_p;
                  slot_wr_row.tail = pid_p;
                  ne_wr_en         = 1'b1;
                  ne_wr_val        = 1'b1;
                  e_status         = ST_BLOCKED;
                end
              end
              REQ_RELEASE: begin
                if (sel_nonempty) begin
                  e_wv  = 1'b1;
                  e_wid = row.head;
                  if (row.head == row.tail) begin
                    ne_wr_en = 1'b1;
                  end else begin
                    // Fetch the next waiter to become head
                    link_rd_en = 1'b1;
                    state_next = S_VNEXT;
                  end
                end else if (row.count != '1) begin
                  slot_wr_en        = 1'b1;
                  slot_wr_row.count = row.count + 1'b1;
                end
              end
              default: begin
                act_wr_en = 1'b1;
                if (sel_nonempty) begin
                  ne_wr_en          = 1'b1;
                  e_status          = ST_FREED;
                  e_last            = 1'b0;
                  walk_w_next       = row.head;
                  walk_from_rd_next = 1'b0;
                  walk_n_next       = '0;
                  state_next        = S_WALK;
                end
              end
            endcase
          end
        end
      end

      S_VNEXT: begin
        slot_wr_en       = 1'b1;
        slot_wr_row.head = link_rd_data;
        state_next       = S_IDLE;
      end

      S_WALK: begin
        if (out_free) begin
          emit     = 1'b1;
          e_status = ST_WAITER;
          e_wv     = 1'b1;
          e_wid    = cur_w;
          e_wk     = 1'b1;
          e_last   = walk_end;
          if (walk_end) begin
            state_next = S_IDLE;
          end else begin
            link_rd_en        = 1'b1;
            link_rd_addr      = cur_w;
            walk_from_rd_next = 1'b1;
            walk_n_next       = walk_t'(walk_n + 1'b1);
          end
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      slot_active   <= '0;
      slot_nonempty <= '0;
      out_valid     <= 1'b0;
    end else begin
      state <= state_next;
      if (act_wr_en) begin
        slot_active[act_wr_addr] <= act_wr_val;
      end
      if (ne_wr_en) begin
        slot_nonempty[ne_wr_addr] <= ne_wr_val;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers: no reset
  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      lat_req <= req.req_type;
      lat_idx <= req.sem_index;
      lat_cnt <= req.initial_count;
      lat_pid <= req.requester_id;
    end
    walk_w       <= walk_w_next;
    walk_from_rd <= walk_from_rd_next;
    walk_n       <= walk_n_next;
    if (emit) begin
      out_status <= e_status;
      out_handle <= e_handle;
      out_wv     <= e_wv;
      out_wid    <= 5'(e_wid);
      out_wk     <= e_wk;
      out_last   <= e_last;
    end
  end

  assign rsp.valid         = out_valid;
  assign rsp.status        = out_status;
  assign rsp.handle        = out_handle;
  assign rsp.waiter_valid  = out_wv;
  assign rsp.waiter_id     = out_wid;
  assign rsp.waiter_killed = out_wk;
  assign rsp.last          = out_last;

  // A taken request always moves on to the execute step
  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> (state == S_EXEC))
    else $error("accepted request did not enter execute");

  // Only a free with waiters produces a non-final result
  a_nonlast_status: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && !rsp.last) |-> (rsp.status == ST_FREED || rsp.status == ST_WAITER))
    else $error("non-final result with unexpected status");

  // Killed waiters are reported only by the free walk
  a_killed_report: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.waiter_killed) |->
      (rsp.waiter_valid && rsp.status == ST_WAITER))
    else $error("killed waiter reported outside free walk");

  // During the walk the freed slot is already inactive and its queue closed
  a_walk_slot_closed: assert property (@(posedge clk) disable iff (rst)
    (state == S_WALK) |-> (!slot_active[idx_s] && !slot_nonempty[idx_s]))
    else $error("slot still open during free walk");

  // Head write-back only happens for a queue that stays occupied
  a_vnext_queued: assert property (@(posedge clk) disable iff (rst)
    (state == S_VNEXT) |-> (slot_nonempty[idx_s] && slot_active[idx_s]))
    else $error("head update on an empty queue");

endmodule

`default_nettype wire

[tb/sv/tb_counting_semaphore_table_unit.sv]
// Self-checking testbench of the counting semaphore table: directed script, then random traffic.
module tb_counting_semaphore_table_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import cst_pkg::*;

  localparam int CYCLE_LIMIT      = 1_000_000;
  localparam int DRAIN_CYCLES     = 48;
  localparam int RANDOM_PER_PHASE = 98;
  localparam int REPORT_LINES     = 40;

  // Pacing per random phase: quiet, sender gaps, receiver stalls, both lightly
  localparam int IDLE_PCT  [4] = '{0, 54, 0, 11};
  localparam int STALL_PCT [4] = '{0, 0, 54, 11};

  typedef struct packed {
    logic [1:0]         req_type;
    logic [7:0]         sem_index;
    logic signed [15:0] initial_count;
    logic [4:0]         requester_id;
  } sem_req_t;

  typedef struct packed {
    logic [2:0] status;
    logic [4:0] handle;
    logic       waiter_valid;
    logic [4:0] waiter_id;
    logic       waiter_killed;
    logic       last;
  } sem_rsp_t;

  typedef struct packed {
    sem_req_t   item;
    logic [5:0] reps;
    logic       check;
    sem_rsp_t   want;
  } script_row_t;

  logic clk;
  logic rst;

  cst_req_if req_ch();
  cst_rsp_if rsp_ch();

  counting_semaphore_table_unit dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  // Shadow of the semaphore table, updated as each transaction is accepted
  logic  sem_live  [NUM_SEMS];
  cnt_t  sem_units [NUM_SEMS];
  proc_t wq_head   [NUM_SEMS];
  proc_t wq_tail   [NUM_SEMS];
  logic  wq_busy   [NUM_SEMS];
  proc_t proc_next [NUM_PROCS];

  sem_rsp_t    due_results[$];
  script_row_t script[$];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int mismatches     = 0;
  int results_seen   = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic void post(bit keep, logic [2:0] st, logic [4:0] hd, logic wv,
                               logic [4:0] wid, logic wk, logic lst);
    sem_rsp_t r;
    r.status        = st;
    r.handle        = hd;
    r.waiter_valid  = wv;
    r.waiter_id     = wid;
    r.waiter_killed = wk;
    r.last          = lst;
    if (keep) due_results.push_back(r);
  endfunction

  // Work out the results of one request and advance the shadow table.
  // With keep clear only the state moves; the caller supplies the result.
  function automatic void apply_request(sem_req_t it, bit keep);
    slot_t       s;
    proc_t       w;
    proc_t       pid;
    int          free_slot;
    int          walked;
    bit          stop;
    logic [32:0] wide;
    pid = proc_t'(it.requester_id);
    if (it.req_type == REQ_CREATE) begin
      free_slot = -1;
      for (int i = NUM_SEMS - 1; i >= 0; i--) begin
        if (!sem_live[i]) free_slot = i;
      end
      if (it.initial_count < 0 || free_slot < 0) begin
        post(keep, ST_ERROR, 5'd0, 1'b0, 5'd0, 1'b0, 1'b1);
      end else begin
        s    = slot_t'(free_slot);
        wide = 33'(unsigned'(it.initial_count));
        sem_live[s]  = 1'b1;
        sem_units[s] = (wide > COUNT_MAX_W) ? cnt_t'(COUNT_MAX_W) : cnt_t'(wide);
        wq_busy[s]   = 1'b0;
        post(keep, ST_OK, 5'(s), 1'b0, 5'd0, 1'b0, 1'b1);
      end
      return;
    end
    // The bound check rejects an index equal to the table size as well
    if (int'(it.sem_index) >= NUM_SEMS || !sem_live[slot_t'(it.sem_index)]) begin
      post(keep, ST_ERROR, 5'd0, 1'b0, 5'd0, 1'b0, 1'b1);
      return;
    end
    s = slot_t'(it.sem_index);
    case (it.req_type)
      REQ_ACQUIRE: begin
        if (sem_units[s] != '0) begin
          sem_units[s] = sem_units[s] - 1'b1;
          post(keep, ST_OK, 5'd0, 1'b0, 5'd0, 1'b0, 1'b1);
        end else if (int'(it.requester_id) >= NUM_PROCS) begin
          post(keep, ST_ERROR, 5'd0, 1'b0, 5'd0, 1'b0, 1'b1);
        end else begin
          // A process already queued is appended again; its old link is lost
          if (wq_busy[s]) begin
            proc_next[wq_tail[s]] = pid;
          end else begin
            wq_head[s] = pid;
            wq_busy[s] = 1'b1;
          end
          wq_tail[s] = pid;
          post(keep, ST_BLOCKED, 5'd0, 1'b0, 5'd0, 1'b0, 1'b1);
        end
      end
      REQ_RELEASE: begin
        if (wq_busy[s]) begin
          w = wq_head[s];
          if (w == wq_tail[s]) wq_busy[s] = 1'b0;
          else wq_head[s] = proc_next[w];
          post(keep, ST_OK, 5'd0, 1'b1, 5'(w), 1'b0, 1'b1);
        end else begin
          if (33'(sem_units[s]) < COUNT_MAX_W) sem_units[s] = sem_units[s] + 1'b1;
          post(keep, ST_OK, 5'd0, 1'b0, 5'd0, 1'b0, 1'b1);
        end
      end
      REQ_FREE: begin
        sem_live[s] = 1'b0;
        if (!wq_busy[s]) begin
          post(keep, ST_OK, 5'd0, 1'b0, 5'd0, 1'b0, 1'b1);
        end else begin
          post(keep, ST_FREED, 5'd0, 1'b0, 5'd0, 1'b0, 1'b0);
          // Walk to the tail, but a looped chain is cut after WALK_MAX waiters
          w      = wq_head[s];
          walked = 0;
          stop   = 1'b0;
          while (!stop) begin
            stop = (w == wq_tail[s]) || (walked + 1 >= WALK_MAX);
            post(keep, ST_WAITER, 5'd0, 1'b1, 5'(w), 1'b1, stop);
            walked++;
            w = proc_next[w];
          end
          wq_busy[s] = 1'b0;
        end
      end
      default: begin
      end
    endcase
  endfunction

  function automatic void add_row(logic [1:0] op, logic [7:0] idx, logic [15:0] count,
                                  logic [4:0] pid, int reps, bit check, logic [2:0] st,
                                  logic [4:0] hd, logic wv, logic [4:0] wid);
    script_row_t row;
    row.item.req_type      = op;
    row.item.sem_index     = idx;
    row.item.initial_count = count;
    row.item.requester_id  = pid;
    row.reps               = 6'(reps);
    row.check              = check;
    row.want.status        = st;
    row.want.handle        = hd;
    row.want.waiter_valid  = wv;
    row.want.waiter_id     = wid;
    row.want.waiter_killed = 1'b0;
    row.want.last          = 1'b1;
    script.push_back(row);
  endfunction

  // Mostly well-formed traffic on live slots, with a share of raw noise.
  // At least half the slot traffic lands on the lowest live slot so its queue grows.
  function automatic sem_req_t random_request();
    sem_req_t it;
    int       live[$];
    int       pick;
    int       roll;
    it.req_type      = 2'($urandom_range(3));
    it.sem_index     = 8'($urandom_range(255));
    it.initial_count = 16'($urandom);
    it.requester_id  = 5'($urandom_range(31));
    foreach (sem_live[i]) begin
      if (sem_live[i]) live.push_back(i);
    end
    roll = $urandom_range(99);
    if (roll < 8) return it;
    if (roll < 22 || live.size() == 0) begin
      it.req_type = REQ_CREATE;
      case ($urandom_range(9))
        0, 1, 2, 3, 4, 5: it.initial_count = 16'($urandom_range(2));
        6:                it.initial_count = 16'($urandom_range(32767));
        7:                it.initial_count = 16'sh7FFF;
        8:                it.initial_count = 16'h8000 | 16'($urandom);
        default:          it.initial_count = 16'($urandom_range(8, 1));
      endcase
      return it;
    end
    pick = ($urandom_range(1) == 1) ? live[0] : live[$urandom_range(live.size() - 1)];
    it.sem_index = 8'(pick);
    roll = $urandom_range(99);
    if (roll < 50) it.req_type = REQ_ACQUIRE;
    else if (roll < 82) it.req_type = REQ_RELEASE;
    else it.req_type = REQ_FREE;
    return it;
  endfunction

  // Offer one request, hold it until it is accepted, then predict.
  // Valid is only dropped while idling, so back-to-back requests keep it high.
  task automatic push_request(sem_req_t it, bit typed, sem_rsp_t want);
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid         <= 1'b1;
    req_ch.req_type      <= it.req_type;
    req_ch.sem_index     <= it.sem_index;
    req_ch.initial_count <= it.initial_count;
    req_ch.requester_id  <= it.requester_id;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    apply_request(it, !typed);
    if (typed) due_results.push_back(want);
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatches++;
    if (mismatches <= REPORT_LINES) begin
      $display("[%0t] result %0d: %s got %0d, want %0d", $time, results_seen, what, got, want);
    end
  endtask

  // Receiver pacing: redraw ready on every edge
  initial begin : sink_pacing
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Compare every accepted result with the oldest one still due
  always @(posedge clk) begin : result_check
    sem_rsp_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (due_results.size() == 0) begin
        report_mismatch("unexpected result, status", int'(rsp_ch.status), 0);
      end else begin
        want = due_results.pop_front();
        if (rsp_ch.status !== want.status)
          report_mismatch("status", int'(rsp_ch.status), int'(want.status));
        if (rsp_ch.handle !== want.handle)
          report_mismatch("handle", int'(rsp_ch.handle), int'(want.handle));
        if (rsp_ch.waiter_valid !== want.waiter_valid)
          report_mismatch("waiter_valid", int'(rsp_ch.waiter_valid), int'(want.waiter_valid));
        if (rsp_ch.waiter_id !== want.waiter_id)
          report_mismatch("waiter_id", int'(rsp_ch.waiter_id), int'(want.waiter_id));
        if (rsp_ch.waiter_killed !== want.waiter_killed)
          report_mismatch("waiter_killed", int'(rsp_ch.waiter_killed),
                          int'(want.waiter_killed));
        if (rsp_ch.last !== want.last)
          report_mismatch("last", int'(rsp_ch.last), int'(want.last));
      end
      results_seen++;
    end
  end

  // Stop a hung run
  initial begin : watchdog
    int unsigned ticks;
    ticks = 0;
    while (ticks < CYCLE_LIMIT) begin
      @(posedge clk);
      ticks++;
    end
    $display("counting_semaphore_table_unit: mismatch");
    $finish;
  end

  initial begin : stimulus
    sem_req_t it;
    foreach (sem_live[i]) begin
      sem_live[i]  = 1'b0;
      sem_units[i] = '0;
      wq_head[i]   = '0;
      wq_tail[i]   = '0;
      wq_busy[i]   = 1'b0;
    end
    foreach (proc_next[i]) proc_next[i] = '0;

    rst                  <= 1'b1;
    req_ch.valid         <= 1'b0;
    req_ch.req_type      <= REQ_CREATE;
    req_ch.sem_index     <= 8'd0;
    req_ch.initial_count <= 16'sd0;
    req_ch.requester_id  <= 5'd0;

    // Directed script: op, index, count, pid, repeats, typed check, expected result.
    // Untyped rows go through the shadow table.
    // Everything is inactive straight after reset
    add_row(REQ_ACQUIRE, 8'd0,   16'h0000, 5'd5,  1, 1, ST_ERROR,  5'd0, 1'b0, 5'd0);
    add_row(REQ_RELEASE, 8'd31,  16'h0000, 5'd0,  1, 1, ST_ERROR,  5'd0, 1'b0, 5'd0);
    add_row(REQ_FREE,    8'd0,   16'h0000, 5'd0,  1, 1, ST_ERROR,  5'd0, 1'b0, 5'd0);
    // Negative counts are refused, the most negative one too
    add_row(REQ_CREATE,  8'd0,   16'h8000, 5'd0,  1, 1, ST_ERROR,  5'd0, 1'b0, 5'd0);
    add_row(REQ_CREATE,  8'd0,   16'hFFFF, 5'd31, 1, 1, ST_ERROR,  5'd0, 1'b0, 5'd0);
    // Creates take the lowest free slot whatever the index says
    add_row(REQ_CREATE,  8'hFF,  16'h0000, 5'd0,  1, 1, ST_OK,     5'd0, 1'b0, 5'd0);
    add_row(REQ_CREATE,  8'd0,   16'h7FFF, 5'd0,  1, 1, ST_OK,     5'd1, 1'b0, 5'd0);
    // Index equal to the table size, and the top index
    add_row(REQ_ACQUIRE, 8'd32,  16'h0000, 5'd0,  1, 1, ST_ERROR,  5'd0, 1'b0, 5'd0);
    add_row(REQ_RELEASE, 8'd255, 16'hFFFF, 5'd31, 1, 1, ST_ERROR,  5'd0, 1'b0, 5'd0);
    // Block two callers on the empty slot, then wake them oldest first
    add_row(REQ_ACQUIRE, 8'd0,   16'h0000, 5'd31, 1, 1, ST_BLOCKED, 5'd0, 1'b0, 5'd0);
    add_row(REQ_ACQUIRE, 8'd0,   16'h0000, 5'd0,  1, 1, ST_BLOCKED, 5'd0, 1'b0, 5'd0);
    add_row(REQ_RELEASE, 8'd0,   16'h0000, 5'd0,  1, 1, ST_OK,     5'd0, 1'b1, 5'd31);
    add_row(REQ_RELEASE, 8'd0,   16'h0000, 5'd0,  1, 1, ST_OK,     5'd0, 1'b1, 5'd0);
    add_row(REQ_RELEASE, 8'd0,   16'h0000, 5'd0,  1, 1, ST_OK,     5'd0, 1'b0, 5'd0);
    add_row(REQ_ACQUIRE, 8'd0,   16'h0000, 5'd9,  1, 1, ST_OK,     5'd0, 1'b0, 5'd0);
    // Shared link memory: queue 1,2,3 on slot 0, then 2,1 on slot 2, which
    // turns slot 0's chain into a loop that never meets its tail
    add_row(REQ_ACQUIRE, 8'd0,   16'h0000, 5'd1,  1, 1, ST_BLOCKED, 5'd0, 1'b0, 5'd0);
    add_row(REQ_ACQUIRE, 8'd0,   16'h0000, 5'd2,  1, 1, ST_BLOCKED, 5'd0, 1'b0, 5'd0);
    add_row(REQ_ACQUIRE, 8'd0,   16'h0000, 5'd3,  1, 1, ST_BLOCKED, 5'd0, 1'b0, 5'd0);
    add_row(REQ_CREATE,  8'd0,   16'h0000, 5'd0,  1, 1, ST_OK,     5'd2, 1'b0, 5'd0);
    add_row(REQ_ACQUIRE, 8'd2,   16'h0000, 5'd2,  1, 1, ST_BLOCKED, 5'd0, 1'b0, 5'd0);
    add_row(REQ_ACQUIRE, 8'd2,   16'h0000, 5'd1,  1, 1, ST_BLOCKED, 5'd0, 1'b0, 5'd0);
    add_row(REQ_FREE,    8'd0,   16'h0000, 5'd0,  1, 0, ST_OK,     5'd0, 1'b0, 5'd0);
    add_row(REQ_FREE,    8'd2,   16'h0000, 5'd0,  1, 0, ST_OK,     5'd0, 1'b0, 5'd0);
    add_row(REQ_FREE,    8'd1,   16'h0000, 5'd0,  1, 1, ST_OK,     5'd0, 1'b0, 5'd0);
    // Fill the table, overflow it, then free every slot in turn
    add_row(REQ_CREATE,  8'd0,   16'h4000, 5'd0, 32, 0, ST_OK,     5'd0, 1'b0, 5'd0);
    add_row(REQ_CREATE,  8'd0,   16'h0001, 5'd0,  1, 1, ST_ERROR,  5'd0, 1'b0, 5'd0);
    add_row(REQ_FREE,    8'd0,   16'h0000, 5'd0, 32, 0, ST_OK,     5'd0, 1'b0, 5'd0);

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    foreach (script[r]) begin
      for (int k = 0; k < int'(script[r].reps); k++) begin
        it           = script[r].item;
        it.sem_index = it.sem_index + 8'(k);
        push_request(it, script[r].check, script[r].want);
      end
    end

    for (int p = 0; p < 4; p++) begin
      send_idle_pct  = IDLE_PCT[p];
      recv_stall_pct = STALL_PCT[p];
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        // Once, hold the sender off until the table has answered everything
        if (p == 1 && n == RANDOM_PER_PHASE / 2) begin
          req_ch.valid <= 1'b0;
          do @(posedge clk); while (due_results.size() != 0);
        end
        push_request(random_request(), 1'b0, '0);
      end
    end

    // Drain: wait for the last results, then watch for strays
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (due_results.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("counting_semaphore_table_unit: match");
    end else begin
      $display("counting_semaphore_table_unit: mismatch");
    end
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/cst_pkg.sv
hw/rtl/cst_if.sv
hw/rtl/cst_ram.sv
hw/rtl/cst_free_find.sv
hw/rtl/counting_semaphore_table_unit.sv
tb/sv/tb_counting_semaphore_table_unit.sv
